// ----- hw/rtl/radix_digit_emitter_top_defines.svh -----
// Assertion macros shared by the radix digit emitter modules.
// No dependencies; included by the controller and the datapath.
`ifndef RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rde: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rde: next-cycle check failed");

`endif

// ----- hw/rtl/rde_pkg.sv -----
// Package for the radix digit emitter: widths, character codes, register
// indexes, state encoding and the controller/datapath interface structs.
// No dependencies.
package rde_pkg;

   localparam int MAX_SYMBOLS = 16;
   localparam int MAX_DIGITS  = 32;

   localparam int NUM_W   = 32;
   localparam int SIZE_W  = 5;
   localparam int SYM_W   = 8;
   localparam int DIGIT_W = 4;
   localparam int ADDR_W  = 5;
   localparam int CNT_W   = 6;
   localparam int IDX_W   = 2;
   localparam int CSR_W   = 64;

   // Long division retires this many quotient bits per cycle.
   localparam int DIV_STEPS = 8;
   localparam int CHUNKS    = NUM_W / DIV_STEPS;
   localparam int STEP_W    = 2;

   localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

   localparam logic [IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_MINUS  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic div;
      logic emit_minus;
      logic rd;
   } dp_cmd_type;

   typedef struct packed {
      logic alph_ok;
      logic negative;
      logic div_done;
      logic read_last;
   } dp_status_type;

endpackage

// ----- hw/rtl/rde_ctrl.sv -----
// Controller of the radix digit emitter: accept, divide, emit sequencing.
// Depends on rde_pkg and radix_digit_emitter_top_defines.svh.
`include "radix_digit_emitter_top_defines.svh"

module rde_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rde_pkg::dp_status_type status,
   output rde_pkg::dp_cmd_type    cmd
);
   import rde_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && status.alph_ok) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div = 1'b1;
            if (status.div_done) begin
               state_in = status.negative ? ST_MINUS : ST_EMIT;
            end
         end
         ST_MINUS: begin
            // The minus sign goes out while the first digit is being read.
            cmd.emit_minus = 1'b1;
            cmd.rd         = 1'b1;
            state_in       = status.read_last ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            cmd.rd = 1'b1;
            if (status.read_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `RDE_ASSERT_NEXT(a_load_divides, clock, reset, cmd.load, state_ff == ST_DIVIDE)
   `RDE_ASSERT_NEXT(a_last_read_idles, clock, reset, cmd.rd && status.read_last, state_ff == ST_IDLE)

endmodule

// ----- hw/rtl/rde_dp.sv -----
// Datapath of the radix digit emitter: configuration registers, alphabet
// check, iterative divider, digit memory and result stage. Depends on rde_pkg
// and radix_digit_emitter_top_defines.svh.
`include "radix_digit_emitter_top_defines.svh"

module rde_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rde_pkg::IDX_W-1:0]   csr_index,
   input  logic [rde_pkg::CSR_W-1:0]   csr_data,
   input  logic signed [rde_pkg::NUM_W-1:0] req_number,
   input  rde_pkg::dp_cmd_type         cmd,
   output rde_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   output logic [rde_pkg::SYM_W-1:0]   rsp_symbol,
   output logic                        rsp_last
);
   import rde_pkg::*;

   logic [SIZE_W-1:0]    base_size_ff, base_size_in;
   logic [CSR_W-1:0]     sym_low_ff, sym_low_in;
   logic [CSR_W-1:0]     sym_high_ff, sym_high_in;
   logic [2*CSR_W-1:0]   syms_all;

   logic                 neg_ff, neg_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [NUM_W-1:0]     div_quo;
   logic [DIGIT_W-1:0]   div_rem;
   logic                 chunk_last;
   logic [NUM_W-1:0]     num_u;
   logic [ADDR_W-1:0]    rd_addr;

   logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0]   rd_digit_ff;
   logic                 rd_valid_ff;
   logic                 rd_last_ff, rd_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_last_ff, rsp_last_in;

   function automatic logic check_alphabet(input logic [SIZE_W-1:0] size,
                                           input logic [2*CSR_W-1:0] syms);
      logic             ok;
      logic [SYM_W-1:0] si;
      logic [SYM_W-1:0] sj;
      ok = (size >= SIZE_W'(2)) && (size <= SIZE_W'(MAX_SYMBOLS));
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         si = syms[i*SYM_W +: SYM_W];
         if (SIZE_W'(i) < size) begin
            if (si == CH_PLUS || si == CH_MINUS) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
               sj = syms[j*SYM_W +: SYM_W];
               if (SIZE_W'(j) < size && sj == si) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

   assign syms_all = {sym_high_ff, sym_low_ff};
   assign num_u    = req_number;

   // Configuration writes.
   always_comb begin
      base_size_in = base_size_ff;
      sym_low_in   = sym_low_ff;
      sym_high_in  = sym_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BASE_SIZE:    base_size_in = csr_data[SIZE_W-1:0];
            REG_SYMBOLS_LOW:  sym_low_in   = csr_data;
            REG_SYMBOLS_HIGH: sym_high_in  = csr_data;
            default: ;
         endcase
      end
   end

   // Eight restoring division steps per cycle; the remainder stays below
   // the radix, so four bits hold it between steps.
   always_comb begin
      logic [SIZE_W-1:0]  trial;
      logic [DIGIT_W-1:0] r;
      logic [NUM_W-1:0]   q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {r, q[NUM_W-1]};
         q     = {q[NUM_W-2:0], 1'b0};
         if (trial >= base_size_ff) begin
            trial = trial - base_size_ff;
            q[0]  = 1'b1;
         end
         r = trial[DIGIT_W-1:0];
      end
      div_quo = q;
      div_rem = r;
   end

   assign chunk_last = (step_ff == STEP_W'(CHUNKS - 1));
   assign rd_addr    = cnt_ff[ADDR_W-1:0] - ADDR_W'(1);

   always_comb begin
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         neg_in  = num_u[NUM_W-1];
         quo_in  = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
         rem_in  = '0;
         step_in = '0;
         cnt_in  = '0;
      end else if (cmd.div) begin
         quo_in  = div_quo;
         step_in = step_ff + STEP_W'(1);
         if (chunk_last) begin
            rem_in = '0;
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            rem_in = div_rem;
         end
      end else if (cmd.rd) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rd_last_in    = (cnt_ff == CNT_W'(1));
      rsp_valid_in  = rd_valid_ff || cmd.emit_minus;
      rsp_last_in   = cmd.emit_minus ? 1'b0 : rd_last_ff;
      rsp_symbol_in = cmd.emit_minus ? CH_MINUS
                                     : syms_all[{rd_digit_ff, 3'b000} +: SYM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff <= '0;
         sym_low_ff   <= '0;
         sym_high_ff  <= '0;
         neg_ff       <= 1'b0;
         quo_ff       <= '0;
         rem_ff       <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_size_ff <= base_size_in;
         sym_low_ff   <= sym_low_in;
         sym_high_ff  <= sym_high_in;
         neg_ff       <= neg_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= cmd.rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff    <= rd_last_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   // Digit memory: digits are written least significant first and read back
   // in reverse order.
   always_ff @(posedge clock) begin
      if (cmd.div && chunk_last) begin
         digit_mem[cnt_ff[ADDR_W-1:0]] <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_digit_ff <= digit_mem[rd_addr];
      end
   end

   // The digit loop ends on a zero quotient or when the memory is full.
   assign status.alph_ok   = check_alphabet(base_size_ff, syms_all);
   assign status.negative  = neg_ff;
   assign status.div_done  = chunk_last &&
                             ((div_quo == '0) || (cnt_ff == CNT_W'(MAX_DIGITS - 1)));
   assign status.read_last = (cnt_ff == CNT_W'(1));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   `RDE_ASSERT_SAME(a_read_not_empty, clock, reset, cmd.rd, cnt_ff != '0)
   `RDE_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff)

endmodule

// ----- hw/rtl/radix_digit_emitter_top.sv -----
// Top level of the radix digit emitter: controller plus datapath.
// Depends on rde_pkg, rde_ctrl and rde_dp.
//
// Usage: write base_size (index 0), symbols_low (1) and symbols_high (2)
// on the csr_ channel while the block is idle; csr_ready is always high and
// other indexes are ignored. Present a number on req_number with start high;
// it is taken at a rising edge where start is high and busy is low.
// An invalid alphabet (fewer than two symbols, more than sixteen, a repeat,
// or a plus or minus sign among them) takes the item and emits nothing.
// Otherwise the text comes out one character per cycle on rsp_symbol, marked
// by rsp_valid, minus sign first for a negative number, most significant
// digit next, rsp_last on the final character. The receiver cannot stall.
// The divider retires eight quotient bits per cycle and works out each digit
// as a full division of the quotient; the digit memory is then read once
// per cycle, and a minus sign goes out alongside the first read. A new
// item is taken only once busy falls after the last digit is read. A minus
// sign passes through the result register only; a digit passes through the
// read register and then the result register.
// Reset (synchronous, active high) clears the sequencer and all registers
// but the read digit and the last and symbol registers of the result stage;
// the digit memory needs no clearing since every digit is written before
// it is read.
module radix_digit_emitter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [rde_pkg::NUM_W-1:0]  req_number,
   output logic                              rsp_valid,
   output logic [rde_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rde_pkg::IDX_W-1:0]         csr_index,
   input  logic [rde_pkg::CSR_W-1:0]         csr_data
);
   import rde_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rde_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rde_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_number (req_number),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

// ----- bench/radix_digit_emitter_top_tb.sv -----
// Self-checking testbench for radix_digit_emitter_top: directed and random numbers
// under many alphabets, each checked character by character against a local predictor.
// Depends on rde_pkg and the radix_digit_emitter_top RTL.
module radix_digit_emitter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rde_pkg::*;

   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 180;
   localparam int RANDOM_ITEMS    = 170;
   localparam int ITEMS_PER_PHASE = 14;
   localparam int IDLE_PERCENT    = 14;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } text_char_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [NUM_W-1:0]  req_number;
   logic                     rsp_valid;
   logic [SYM_W-1:0]         rsp_symbol;
   logic                     rsp_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [IDX_W-1:0]         csr_index;
   logic [CSR_W-1:0]         csr_data;

   // Predictor copy of the registers.
   logic [SIZE_W-1:0]  radix;
   logic [2*CSR_W-1:0] alphabet;

   text_char_type expected_text[$];
   int unsigned numbers_sent;
   int unsigned rejected_numbers;
   int unsigned chars_checked;
   int unsigned errors;
   bit          idle_on;

   radix_digit_emitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [SYM_W-1:0] glyph(int unsigned digit);
      return alphabet[digit*SYM_W +: SYM_W];
   endfunction

   function automatic bit alphabet_valid();
      logic [SYM_W-1:0] s;
      if (radix < 2 || radix > MAX_SYMBOLS)
         return 1'b0;
      for (int i = 0; i < radix; i++) begin
         s = glyph(i);
         if (s == CH_PLUS || s == CH_MINUS)
            return 1'b0;
         for (int j = i + 1; j < radix; j++)
            if (s == glyph(j))
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queues the characters the block must print for one number.
   function automatic void render_number(logic [NUM_W-1:0] raw);
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      logic [NUM_W-1:0]   mag;
      int unsigned        count;
      if (!alphabet_valid()) begin
         rejected_numbers++;
         return;
      end
      mag = raw[NUM_W-1] ? (~raw + 1'b1) : raw;
      count = 0;
      do begin
         digits[count] = DIGIT_W'(mag % radix);
         count++;
         mag = mag / radix;
      end while (mag != 0 && count < MAX_DIGITS);
      if (raw[NUM_W-1])
         expected_text.push_back('{symbol: CH_MINUS, last: 1'b0});
      for (int n = count - 1; n >= 0; n--)
         expected_text.push_back('{symbol: glyph(digits[n]), last: (n == 0)});
   endfunction

   function automatic logic [2*CSR_W-1:0] text_alphabet(string s);
      logic [2*CSR_W-1:0] a;
      a = '0;
      for (int i = 0; i < s.len(); i++)
         a[i*SYM_W +: SYM_W] = s[i];
      return a;
   endfunction

   // Distinct symbols in the slots in use, never a sign; unused slots are anything.
   function automatic logic [2*CSR_W-1:0] random_alphabet(int unsigned size);
      logic [2*CSR_W-1:0] a;
      bit                 used [256];
      logic [SYM_W-1:0]   s;
      a = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < size; i++) begin
         do
            s = SYM_W'($urandom_range(0, 255));
         while (used[s] || s == CH_PLUS || s == CH_MINUS);
         used[s] = 1'b1;
         a[i*SYM_W +: SYM_W] = s;
      end
      return a;
   endfunction

   function automatic logic [NUM_W-1:0] random_number();
      logic [NUM_W-1:0] n;
      case ($urandom_range(0, 9))
         0: begin
            n = $urandom_range(0, 40);
            if ($urandom_range(0, 1))
               n = ~n + 1'b1;
         end
         1: case ($urandom_range(0, 3))
            0: n = 32'h8000_0000;
            1: n = 32'h7FFF_FFFF;
            2: n = 32'hFFFF_FFFF;
            default: n = '0;
         endcase
         default: n = $urandom;
      endcase
      return n;
   endfunction

   // Every character on the result port must match the oldest pending one.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid) begin
         chars_checked++;
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual symbol %h last %b",
                     $time, rsp_symbol, rsp_last);
            errors++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $display("%0t: symbol mismatch, expected %h, actual %h",
                        $time, want.symbol, rsp_symbol);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Leaves start high on return unless an idle gap was taken.
   task automatic send_number(input logic [NUM_W-1:0] n);
      start      <= 1'b1;
      req_number <= n;
      do
         @(posedge clock);
      while (busy);
      render_number(n);
      numbers_sent++;
      if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Leaves csr_valid high so that back-to-back writes keep it steady.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_BASE_SIZE:    radix = data[SIZE_W-1:0];
         REG_SYMBOLS_LOW:  alphabet[CSR_W-1:0] = data;
         REG_SYMBOLS_HIGH: alphabet[2*CSR_W-1:CSR_W] = data;
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned size, input logic [2*CSR_W-1:0] symbols);
      logic [CSR_W-1:0] size_word;
      size_word = {$urandom, $urandom};
      size_word[SIZE_W-1:0] = SIZE_W'(size);
      write_reg(REG_BASE_SIZE, size_word);
      write_reg(REG_SYMBOLS_LOW, symbols[CSR_W-1:0]);
      write_reg(REG_SYMBOLS_HIGH, symbols[2*CSR_W-1:CSR_W]);
      csr_idle();
   endtask

   // Wait for every pending character, then let the clock run on with start low.
   task automatic settle();
      start <= 1'b0;
      while (expected_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_alphabet();
      // After reset the radix is zero, so items are taken and print nothing.
      send_number(-5);
      send_number(123);
      settle();
   endtask

   task automatic test_decimal();
      configure(10, text_alphabet("0123456789"));
      send_number(0);
      send_number(1);
      send_number(-1);
      send_number(10);
      send_number(-10);
      send_number(32'h7FFF_FFFF);
      send_number(32'h8000_0000);
      settle();
   endtask

   task automatic test_binary();
      configure(2, text_alphabet("01"));
      send_number(32'h8000_0000);
      send_number(32'h7FFF_FFFF);
      send_number(32'hFFFF_FFFF);
      send_number(1);
      settle();
   endtask

   task automatic test_hex_zero_symbol();
      logic [2*CSR_W-1:0] a;
      // Symbol i is byte i*0x11, so a zero byte stands for digit zero.
      for (int i = 0; i < MAX_SYMBOLS; i++)
         a[i*SYM_W +: SYM_W] = SYM_W'(i * 8'h11);
      configure(16, a);
      send_number(0);
      send_number(32'h8000_0000);
      send_number(32'hFFFF_FFFF);
      send_number(32'h7FFF_FFFF);
      settle();
   endtask

   task automatic test_bad_alphabets();
      logic [2*CSR_W-1:0] a;
      configure(1, text_alphabet("0123456789abcdef"));
      send_number(77);
      settle();
      configure(17, text_alphabet("0123456789abcdef"));
      send_number(-77);
      settle();
      configure(31, text_alphabet("0123456789abcdef"));
      send_number(32'h8000_0000);
      settle();
      configure(10, text_alphabet("0123456783"));
      send_number(1234);
      settle();
      a = text_alphabet("0123456789abcdef");
      a[15*SYM_W +: SYM_W] = CH_PLUS;
      configure(16, a);
      send_number(-1);
      settle();
      a = text_alphabet("x123456789abcdef");
      a[0 +: SYM_W] = CH_MINUS;
      configure(8, a);
      send_number(8);
      settle();
      // A sign outside the symbols in use does not spoil the alphabet.
      a = text_alphabet("0123456789abcdef");
      a[12*SYM_W +: SYM_W] = CH_PLUS;
      configure(10, a);
      send_number(-42);
      settle();
      // Writes to the unused register index must change nothing.
      write_reg(REG_UNUSED, {$urandom, $urandom});
      csr_idle();
      send_number(-907);
      settle();
   endtask

   task automatic test_random();
      int unsigned        phase;
      int unsigned        size;
      logic [2*CSR_W-1:0] a;
      int unsigned        slot;
      phase = 0;
      while (numbers_sent < RANDOM_ITEMS) begin
         // The first phases run with start held high throughout.
         idle_on = (phase >= 3);
         size = (phase == 0) ? 2 : (phase == 1) ? 16 : $urandom_range(2, 16);
         a = random_alphabet(size);
         if (phase >= 2 && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: size = $urandom_range(0, 1);
               1: size = $urandom_range(17, 31);
               2: begin
                  slot = $urandom_range(1, size - 1);
                  a[slot*SYM_W +: SYM_W] = a[$urandom_range(0, slot - 1)*SYM_W +: SYM_W];
               end
               default: a[$urandom_range(0, size - 1)*SYM_W +: SYM_W] =
                           $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            endcase
         end
         configure(size, a);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (phase == 5 && i == ITEMS_PER_PHASE / 2) begin
               // Hold off until the block has printed everything so far.
               start <= 1'b0;
               while (expected_text.size() != 0)
                  @(posedge clock);
               @(posedge clock);
            end
            send_number(random_number());
         end
         settle();
         phase++;
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_number       = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_BASE_SIZE;
      csr_data         = '0;
      radix            = '0;
      alphabet         = '0;
      numbers_sent     = 0;
      rejected_numbers = 0;
      chars_checked    = 0;
      errors           = 0;
      idle_on          = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_alphabet();
      test_decimal();
      test_binary();
      test_hex_zero_symbol();
      test_bad_alphabets();
      test_random();
      settle();

      $display("Printed %0d numbers in bases two to sixteen, %0d characters compared;",
               numbers_sent - rejected_numbers, chars_checked);
      $display("%0d numbers were given under rejected alphabets and printed nothing.",
               rejected_numbers);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
